// ----- sv/tqsg_pkg.sv -----
package tqsg_pkg;

    // Queue and sine table sizes.
    localparam int QUEUE_DEPTH     = 16;
    localparam int PHASE_BITS      = 24;
    localparam int SINE_TABLE_BITS = 8;

    // Field widths fixed by the stream format.
    localparam int STEP_W   = 24;
    localparam int LENGTH_W = 24;
    localparam int SAMPLE_W = 8;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 3;
    localparam int COUNTER_W = 32;

    localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
    localparam int QUARTER    = TABLE_SIZE / 4;

    localparam logic [63:0] HALF_PI_Q30 = 64'h6487ED51;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Item kinds carried on the slave-side tuser bit.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SAMPLE  = 1'b1;

    typedef logic [SAMPLE_W-1:0] sine_rom_t [TABLE_SIZE];

    // Sine of a folded angle index in Q30, Taylor series with integer truncation.
    // Terms beyond the tenth are zero for every angle up to a quarter turn.
    function automatic logic [63:0] sine_q30(input int unsigned r);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        if (r == 0) begin
            s = '0;
        end
        else if (r >= QUARTER) begin
            s = ONE_Q30;
        end
        else begin
            a  = (64'(r) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
            a2 = (a * a) >> 30;
            t  = a;
            s  = a;
            t  = ((t * a2) >> 30) / 6;    s = s - t;
            t  = ((t * a2) >> 30) / 20;   s = s + t;
            t  = ((t * a2) >> 30) / 42;   s = s - t;
            t  = ((t * a2) >> 30) / 72;   s = s + t;
            t  = ((t * a2) >> 30) / 110;  s = s - t;
            t  = ((t * a2) >> 30) / 156;  s = s + t;
            t  = ((t * a2) >> 30) / 210;  s = s - t;
            t  = ((t * a2) >> 30) / 272;  s = s + t;
            t  = ((t * a2) >> 30) / 342;  s = s - t;
            t  = ((t * a2) >> 30) / 420;  s = s + t;
        end
        return s;
    endfunction

    // Offset-binary sine table, evaluated at elaboration.
    function automatic sine_rom_t build_rom();
        sine_rom_t   rom;
        int unsigned q;
        int unsigned r;
        logic [63:0] s;
        logic [63:0] mag;
        logic [63:0] v;
        for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
            q = k >> (SINE_TABLE_BITS - 2);
            r = k & (QUARTER - 1);
            if (q[0]) begin
                r = QUARTER - r;
            end
            s   = sine_q30(r);
            mag = (64'd255 * s + ONE_Q30) >> 31;
            if (q >= 2) begin
                v = (mag >= 64'd128) ? 64'd0 : (64'd128 - mag);
            end
            else begin
                v = (mag + 64'd128 > 64'd255) ? 64'd255 : (mag + 64'd128);
            end
            rom[k] = v[SAMPLE_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    // Circular queue pointer advance.
    function automatic logic [QUEUE_IDX_W-1:0] queue_inc(input logic [QUEUE_IDX_W-1:0] x);
        return (x == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

endpackage

// ----- sv/tone_queue_sine_generator_top.sv -----
// The result of an item passes the process, table and output registers to the master side.
// Throughput: one item per cycle while the master side is not stalled; the tone queue is two
// memories with registered reads, forwarded from a write to the same entry, so items may follow back to back.
// Reset (rst_n low, asynchronous) empties the queue and clears the sample counter and the
// pipeline; queue memory contents are not cleared, as only written entries are ever used.
module tone_queue_sine_generator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tqsg_pkg::S_DATA_W-1:0] s_tdata,   // phase_step[23:0], tone_length[47:24]
    input  logic                          s_tuser,   // cmd[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tqsg_pkg::M_DATA_W-1:0] m_tdata,   // sample[7:0]
    output logic [tqsg_pkg::M_USER_W-1:0] m_tuser    // sample_valid[0], queue_empty[1],
                                                     // enqueue_ok[2]
);

    localparam int QW = tqsg_pkg::QUEUE_IDX_W;
    localparam int CW = tqsg_pkg::QUEUE_CNT_W;
    localparam int PB = tqsg_pkg::PHASE_BITS;
    localparam int TB = tqsg_pkg::SINE_TABLE_BITS;

    // Tone queue storage. Step and length live in separate memories so that the
    // step of the current head and the length of the entry behind it can be read
    // in the same cycle.
    logic [tqsg_pkg::STEP_W-1:0]   step_mem [tqsg_pkg::QUEUE_DEPTH];
    logic [tqsg_pkg::LENGTH_W-1:0] len_mem  [tqsg_pkg::QUEUE_DEPTH];
    logic [tqsg_pkg::STEP_W-1:0]   step_rd_reg;
    logic [tqsg_pkg::LENGTH_W-1:0] len_rd_reg;

    // Queue control and tone state.
    logic [QW-1:0]                  head_reg,      head_next;
    logic [QW-1:0]                  tail_reg,      tail_next;
    logic [CW-1:0]                  count_reg,     count_next;
    logic [tqsg_pkg::LENGTH_W-1:0]  remaining_reg, remaining_next;
    logic [tqsg_pkg::COUNTER_W-1:0] counter_reg,   counter_next;
    logic [tqsg_pkg::LENGTH_W-1:0]  remaining_dec;
    logic                           wr_en;

    // Process stage: the accepted item, which meets the memory read data here.
    logic                          p_valid_reg;
    logic                          p_cmd_reg;
    logic [tqsg_pkg::STEP_W-1:0]   p_step_reg;
    logic [tqsg_pkg::LENGTH_W-1:0] p_len_reg;

    // Table stage: registered phase index and result flags.
    logic          m_valid_reg;
    logic [TB-1:0] m_idx_reg;
    logic          m_sv_reg;
    logic          m_empty_reg;
    logic          m_ok_reg;

    // Output register.
    logic                          o_valid_reg;
    logic [tqsg_pkg::SAMPLE_W-1:0] o_sample_reg;
    logic                          o_sv_reg;
    logic                          o_empty_reg;
    logic                          o_ok_reg;

    logic          o_ready;
    logic          m_ready;
    logic          m_adv;
    logic          p_ready;
    logic          p_adv;
    logic          res_sv;
    logic          res_ok;
    logic [PB-1:0] phase;

    // Each stage moves on when the one after it is empty or moving on itself.
    assign o_ready  = !o_valid_reg || m_tready;
    assign m_ready  = !m_valid_reg || o_ready;
    assign m_adv    = m_valid_reg && o_ready;
    assign p_ready  = !p_valid_reg || m_ready;
    assign p_adv    = p_valid_reg && m_ready;
    assign s_tready = p_ready;

    // Phase is the global sample counter times the head tone's step, wrapped to
    // the phase width; its top bits address the sine table in the next stage.
    assign phase = counter_reg[PB-1:0] * PB'(step_rd_reg);

    // Queue update. State only changes when the processed item moves on, so a
    // stalled item keeps seeing the same head entry.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        counter_next   = counter_reg;
        remaining_dec  = remaining_reg;
        wr_en          = 1'b0;
        res_sv         = 1'b0;
        res_ok         = 1'b0;
        if (p_adv)
        begin
            case (p_cmd_reg)
                tqsg_pkg::CMD_ENQUEUE:
                begin
                    // A full queue or a zero length rejects the tone.
                    if (count_reg != CW'(tqsg_pkg::QUEUE_DEPTH) && p_len_reg != '0)
                    begin
                        wr_en = 1'b1;
                        if (count_reg == '0)
                        begin
                            remaining_next = p_len_reg;
                        end
                        tail_next  = tqsg_pkg::queue_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                        res_ok     = 1'b1;
                    end
                end
                tqsg_pkg::CMD_SAMPLE:
                begin
                    // With an empty queue nothing moves, not even the counter.
                    if (count_reg != '0)
                    begin
                        res_sv       = 1'b1;
                        counter_next = counter_reg + 1'b1;
                        if (remaining_reg != '0)
                        begin
                            remaining_dec = remaining_reg - 1'b1;
                        end
                        remaining_next = remaining_dec;
                        if (remaining_dec == '0)
                        begin
                            // The head tone is done; the next one, if any, loads
                            // its length from the entry read behind the head.
                            head_next  = tqsg_pkg::queue_inc(head_reg);
                            count_next = count_reg - 1'b1;
                            if (count_reg != CW'(1))
                            begin
                                remaining_next = len_rd_reg;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Memories are read every cycle at the head that the next item will see.
    // A write to the entry being read is forwarded into the read register.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            step_mem[tail_reg] <= p_step_reg;
            len_mem[tail_reg]  <= p_len_reg;
        end
        if (wr_en && tail_reg == head_next)
        begin
            step_rd_reg <= p_step_reg;
        end
        else
        begin
            step_rd_reg <= step_mem[head_next];
        end
        if (wr_en && tail_reg == tqsg_pkg::queue_inc(head_next))
        begin
            len_rd_reg <= p_len_reg;
        end
        else
        begin
            len_rd_reg <= len_mem[tqsg_pkg::queue_inc(head_next)];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            remaining_reg <= '0;
            counter_reg   <= '0;
            p_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            o_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            counter_reg   <= counter_next;
            if (p_ready)
            begin
                p_valid_reg <= s_tvalid;
            end
            if (m_ready)
            begin
                m_valid_reg <= p_adv;
            end
            if (o_ready)
            begin
                o_valid_reg <= m_adv;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && p_ready)
        begin
            p_cmd_reg  <= s_tuser;
            p_step_reg <= s_tdata[tqsg_pkg::STEP_W-1:0];
            p_len_reg  <= s_tdata[tqsg_pkg::STEP_W +: tqsg_pkg::LENGTH_W];
        end
        if (p_adv)
        begin
            m_idx_reg   <= phase[PB-1 -: TB];
            m_sv_reg    <= res_sv;
            m_empty_reg <= (count_next == '0);
            m_ok_reg    <= res_ok;
        end
        if (m_adv)
        begin
            o_sample_reg <= m_sv_reg ? tqsg_pkg::SINE_ROM[m_idx_reg] : '0;
            o_sv_reg     <= m_sv_reg;
            o_empty_reg  <= m_empty_reg;
            o_ok_reg     <= m_ok_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_sample_reg;
    assign m_tuser  = {o_ok_reg, o_empty_reg, o_sv_reg};

endmodule

// ----- sim/tone_queue_sine_generator_top_tb.sv -----
module tone_queue_sine_generator_top_tb;

    // Geometry and field widths of the block under test.
    localparam int SINE_TABLE_BITS = tqsg_pkg::SINE_TABLE_BITS;
    localparam int PHASE_BITS      = tqsg_pkg::PHASE_BITS;
    localparam int QUEUE_DEPTH     = tqsg_pkg::QUEUE_DEPTH;
    localparam int STEP_W          = tqsg_pkg::STEP_W;
    localparam int LENGTH_W        = tqsg_pkg::LENGTH_W;
    localparam int SAMPLE_W        = tqsg_pkg::SAMPLE_W;
    localparam int S_DATA_W        = tqsg_pkg::S_DATA_W;
    localparam int M_DATA_W        = tqsg_pkg::M_DATA_W;
    localparam int M_USER_W        = tqsg_pkg::M_USER_W;
    localparam int COUNTER_W       = tqsg_pkg::COUNTER_W;

    // Sine table geometry, as the block uses it.
    localparam int LUT_SIZE = 1 << SINE_TABLE_BITS;
    localparam int LUT_QTR  = LUT_SIZE / 4;

    // Random part of the stimulus, in input transfers.
    localparam int RANDOM_ITEMS = 1650;
    // Where the sender waits for the block to run dry in the middle of the run.
    localparam int MID_PAUSE_AT = 800;
    // The receiver holds off once, after this many results, for this many cycles.
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    // Longest idle or stall drawn per transfer on either side.
    localparam int GAP_MAX = 18;
    // Cycles without any transfer before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;
    // Cycles run after the last result, so that a stray result would still be caught.
    localparam int TAIL_CYCLES = 8;

    typedef longint unsigned u64_t;

    // How densely a side offers or takes transfers in a stretch of the run.
    typedef enum int {PACE_BURST, PACE_SPREAD, PACE_MIXED} pace_t;

    // One input item together with the idle cycles that come before it.
    typedef struct {
        logic                cmd;
        logic [STEP_W-1:0]   step;
        logic [LENGTH_W-1:0] length;
        int                  lead_gap;
        bit                  wait_empty;
    } tone_req_t;

    // One result item, split into its fields.
    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                sample_valid;
        logic                queue_empty;
        logic                enqueue_ok;
    } tone_out_t;

    // Every input starts at a known value; reset is low from time zero.
    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = tqsg_pkg::CMD_ENQUEUE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    tone_queue_sine_generator_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the block: the tone FIFO, the remaining length of the head tone,
    // the global sample counter and the offset-binary sine table.
    logic [SAMPLE_W-1:0]  sine_lut  [LUT_SIZE];
    logic [STEP_W-1:0]    tone_step [QUEUE_DEPTH];
    logic [LENGTH_W-1:0]  tone_len  [QUEUE_DEPTH];
    int unsigned          tone_head;
    int unsigned          tone_tail;
    int unsigned          tones_held;
    logic [LENGTH_W-1:0]  head_left;
    logic [COUNTER_W-1:0] sample_count;

    // Items still to be sent, and results predicted but not yet seen.
    tone_req_t stim_items[$];
    tone_out_t predicted_outputs[$];

    // Transfer counts on both sides, updated at the clock edge.
    int sent_count    = 0;
    int checked_count = 0;

    int    fail_count = 0;
    int    n_sounded  = 0;
    int    n_silent   = 0;
    int    n_refused  = 0;
    pace_t pace       = PACE_SPREAD;

    // Sine of a folded angle index in Q30, summed as a Taylor series with
    // truncation after every step, until a term vanishes.
    function automatic u64_t quarter_sine_q30(int unsigned r);
        u64_t a;
        u64_t a2;
        u64_t term;
        u64_t sum;
        bit   minus;
        if (r == 0)
        begin
            return 0;
        end
        if (r >= LUT_QTR)
        begin
            return tqsg_pkg::ONE_Q30;
        end
        a     = (u64_t'(r) * tqsg_pkg::HALF_PI_Q30) / LUT_QTR;
        a2    = (a * a) >> 30;
        term  = a;
        sum   = a;
        minus = 1'b1;
        for (int n = 1; n < 40 && term != 0; n++)
        begin
            term  = ((term * a2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
            sum   = minus ? sum - term : sum + term;
            minus = !minus;
        end
        return sum;
    endfunction

    // Offset-binary table: 128 plus or minus the rounded magnitude, kept in 0..255.
    function automatic void fill_sine_lut();
        int unsigned quad;
        int unsigned r;
        u64_t        mag;
        for (int k = 0; k < LUT_SIZE; k++)
        begin
            quad = k / LUT_QTR;
            r    = k % LUT_QTR;
            if ((quad & 1) != 0)
            begin
                r = LUT_QTR - r;
            end
            mag = (u64_t'(255) * quarter_sine_q30(r) + tqsg_pkg::ONE_Q30) >> 31;
            if (quad >= 2)
            begin
                sine_lut[k] = (mag >= 128) ? '0 : SAMPLE_W'(128 - mag);
            end
            else
            begin
                sine_lut[k] = (mag + 128 > 255) ? '1 : SAMPLE_W'(mag + 128);
            end
        end
    endfunction

    // Applies one item to the shadow state and returns the result it must cause.
    function automatic tone_out_t play_tone_item(tone_req_t req);
        tone_out_t res;
        u64_t      phase;
        res.sample       = '0;
        res.sample_valid = 1'b0;
        res.enqueue_ok   = 1'b0;
        if (req.cmd == tqsg_pkg::CMD_ENQUEUE)
        begin
            if (tones_held < QUEUE_DEPTH && req.length != 0)
            begin
                tone_step[tone_tail] = req.step;
                tone_len[tone_tail]  = req.length;
                if (tones_held == 0)
                begin
                    head_left = req.length;
                end
                tone_tail      = (tone_tail + 1) % QUEUE_DEPTH;
                tones_held     = tones_held + 1;
                res.enqueue_ok = 1'b1;
            end
            else
            begin
                n_refused++;
            end
        end
        else if (tones_held != 0)
        begin
            // Phase is the global counter times the head tone's step, wrapped to
            // the phase width; its top bits pick the table entry.
            phase = (u64_t'(sample_count) * u64_t'(tone_step[tone_head]))
                    & ((u64_t'(1) << PHASE_BITS) - 1);
            res.sample       = sine_lut[phase >> (PHASE_BITS - SINE_TABLE_BITS)];
            res.sample_valid = 1'b1;
            sample_count     = sample_count + 1'b1;
            if (head_left != 0)
            begin
                head_left = head_left - 1'b1;
            end
            if (head_left == 0)
            begin
                tone_head  = (tone_head + 1) % QUEUE_DEPTH;
                tones_held = tones_held - 1;
                if (tones_held != 0)
                begin
                    head_left = tone_len[tone_head];
                end
            end
            n_sounded++;
        end
        else
        begin
            n_silent++;
        end
        res.queue_empty = (tones_held == 0);
        return res;
    endfunction

    function automatic int draw_gap(pace_t mode);
        case (mode)
            PACE_BURST:  return 0;
            PACE_SPREAD: return $urandom_range(0, GAP_MAX);
            default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(1, GAP_MAX) : 0;
        endcase
    endfunction

    function automatic void push_req(logic cmd, logic [STEP_W-1:0] step,
                                     logic [LENGTH_W-1:0] length);
        tone_req_t req;
        req.cmd        = cmd;
        req.step       = step;
        req.length     = length;
        req.lead_gap   = draw_gap(pace);
        req.wait_empty = 1'b0;
        stim_items.push_back(req);
    endfunction

    // Mostly full-width steps, some slow tones and now and then a silent one.
    function automatic logic [STEP_W-1:0] draw_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1, 2:    return STEP_W'($urandom_range(1, 4095));
            default: return STEP_W'($urandom());
        endcase
    endfunction

    // Builds the whole stimulus: a directed opening, random well-formed
    // enqueue-then-play sequences with noise mixed in, and a closing phase with
    // long tones that fill the queue.
    task automatic build_stimulus();
        int burst;
        int play;
        int mark;
        pace = PACE_SPREAD;
        // Sample request on an empty queue, with every data bit high.
        push_req(tqsg_pkg::CMD_SAMPLE, '1, '1);
        // A zero-length tone is refused.
        push_req(tqsg_pkg::CMD_ENQUEUE, 24'h123456, '0);
        // Largest step, shortest tone; the counter is still zero here.
        push_req(tqsg_pkg::CMD_ENQUEUE, '1, 24'd1);
        push_req(tqsg_pkg::CMD_SAMPLE, '0, '0);
        // Half-cycle step over two samples, then one request past its end.
        push_req(tqsg_pkg::CMD_ENQUEUE, 24'h800000, 24'd2);
        push_req(tqsg_pkg::CMD_SAMPLE, '0, '0);
        push_req(tqsg_pkg::CMD_SAMPLE, '0, '0);
        push_req(tqsg_pkg::CMD_SAMPLE, '0, '0);
        // Fill the queue with one-sample tones, then try one more.
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            push_req(tqsg_pkg::CMD_ENQUEUE, (i == 0) ? 24'd1 : draw_step(), 24'd1);
        end
        push_req(tqsg_pkg::CMD_ENQUEUE, '0, 24'd5);

        while (stim_items.size() < RANDOM_ITEMS)
        begin
            pace  = pace_t'((stim_items.size() / 150) % 3);
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 5);
            play  = 0;
            for (int j = 0; j < burst; j++)
            begin
                mark = $urandom_range(1, 6);
                play += mark;
                push_req(tqsg_pkg::CMD_ENQUEUE, draw_step(), LENGTH_W'(mark));
            end
            // Play roughly what was queued, sometimes a little short, sometimes over.
            play = play + $urandom_range(0, 4) - 2;
            for (int j = 0; j < play; j++)
            begin
                push_req(tqsg_pkg::CMD_SAMPLE, draw_step(), LENGTH_W'($urandom()));
                if ($urandom_range(0, 11) == 0)
                begin
                    push_req(tqsg_pkg::CMD_ENQUEUE, draw_step(), '0);
                end
            end
        end
        stim_items[MID_PAUSE_AT].wait_empty = 1'b1;

        // Closing phase: start from an idle block, then queue long tones whose
        // lengths cover the upper bits, overflow the queue and play a while.
        pace = PACE_MIXED;
        mark = stim_items.size();
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            push_req(tqsg_pkg::CMD_ENQUEUE, draw_step(),
                     LENGTH_W'($urandom_range(1, 24'hFFFFFF)));
        end
        stim_items[mark].wait_empty = 1'b1;
        push_req(tqsg_pkg::CMD_ENQUEUE, '1, '1);
        for (int i = 0; i < 20; i++)
        begin
            push_req(tqsg_pkg::CMD_SAMPLE, draw_step(), '0);
        end
    endtask

    // Driver. Items leave the queue one transfer at a time; each one first waits
    // out its idle gap, and a marked item also waits until every result is back.
    tone_req_t on_bus;
    int        gap_left  = 0;
    bit        gap_armed = 1'b0;
    bit        launch;
    bit        all_settled;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= tqsg_pkg::CMD_ENQUEUE;
            sent_count <= 0;
        end
        else
        begin
            launch      = 1'b0;
            all_settled = (sent_count + (s_tvalid && s_tready))
                          == (checked_count + (m_tvalid && m_tready));
            if (s_tvalid && s_tready)
            begin
                predicted_outputs.push_back(play_tone_item(on_bus));
                sent_count <= sent_count + 1;
            end
            if ((!s_tvalid || s_tready) && stim_items.size() != 0)
            begin
                if (!gap_armed)
                begin
                    gap_left  = stim_items[0].lead_gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (!stim_items[0].wait_empty || all_settled)
                begin
                    launch = 1'b1;
                end
            end
            // Exactly one assignment to s_tvalid per edge, so a valid that stays
            // high across back-to-back transfers never dips.
            if (launch)
            begin
                on_bus    = stim_items.pop_front();
                gap_armed = 1'b0;
                s_tvalid  <= 1'b1;
                s_tdata   <= {on_bus.length, on_bus.step};
                s_tuser   <= on_bus.cmd;
            end
            else if (!s_tvalid || s_tready)
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Four-state compare, so an unknown bit on the bus counts as a mismatch.
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor. Every result transfer is matched against the oldest prediction.
    // The ready side stalls a drawn number of cycles after each transfer, and
    // once holds off for a long stretch so that the block backs up into its input.
    int        stall_left = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;
    bit        ready_next;
    tone_out_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            checked_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                checked_count <= checked_count + 1;
                if (predicted_outputs.size() == 0)
                begin
                    $error("result transfer with no item waiting for one");
                    fail_count++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    check_field("sample", 32'(want.sample), 32'(m_tdata));
                    check_field("sample_valid", 32'(want.sample_valid), 32'(m_tuser[0]));
                    check_field("queue_empty", 32'(want.queue_empty), 32'(m_tuser[1]));
                    check_field("enqueue_ok", 32'(want.enqueue_ok), 32'(m_tuser[2]));
                end
                if (!hold_done && checked_count == HOLD_AT)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                stall_left = draw_gap(pace_t'((checked_count / 200) % 3));
            end
            if (hold_left != 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means a hang.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        fill_sine_lut();
        tone_head    = 0;
        tone_tail    = 0;
        tones_held   = 0;
        head_left    = '0;
        sample_count = '0;
        build_stimulus();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Run until every item has gone out and every result has come back, then
        // give the block a few more cycles to show any stray result.
        while (stim_items.size() != 0 || s_tvalid || predicted_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d tone samples, %0d requests on an empty queue, %0d refused.",
                 sent_count, n_sounded, n_silent, n_refused);
        $display("Queue filled to depth, receiver held off %0d cycles, sender paused twice.",
                 HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- tone_queue_sine_generator_top.f -----
sv/tqsg_pkg.sv
sv/tone_queue_sine_generator_top.sv
sim/tone_queue_sine_generator_top_tb.sv
